// ===== hdl/lstt_pkg.sv =====
package lstt_pkg;

  localparam int unsigned TabW    = 6;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned TabSizeMax = 63;

  localparam logic [TabW-1:0]  TAB_SIZE_RESET = 6'd8;
  localparam logic [ByteW-1:0] CH_TAB         = 8'd9;
  localparam logic [ByteW-1:0] CH_NEWLINE     = 8'd10;
  localparam logic [ByteW-1:0] CH_SPACE       = 8'd32;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
  } out_beat_t;

  // what one accepted beat produces: leading spaces, then optionally one char
  typedef struct packed {
    logic [TabW-1:0]  spaces;
    logic             has_char;
    logic [ByteW-1:0] emit_char;
    logic [TabW-1:0]  count_next;
    logic             recording_next;
  } act_t;

endpackage

// ===== hdl/leading_space_to_tab.sv =====
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_stall_o | in_beat_i  (in_byte, end_of_stream)
// out     | out | out_valid_o/out_stall_i | out_beat_o (out_byte, last_of_run)
// cfg     | in  | cfg_we_i              | cfg_wdata_i (tab_size)
//
// One input beat per cycle when no flush is draining and the output is not
// stalled; a beat's first result shows in the cycle after it is accepted.
// A flush of N leftover spaces (plus the passed byte) drains one result beat
// at a time; the input is stalled while the remainder drains.
// Reset: count 0, recording on, tab size 8, output empty.
// Output stall freezes the output register and the drain; input stalls too.
module leading_space_to_tab (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lstt_pkg::in_beat_t          in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lstt_pkg::out_beat_t         out_beat_o,
  input  logic                        cfg_we_i,
  input  logic [lstt_pkg::TabW-1:0]   cfg_wdata_i
);

  logic [lstt_pkg::TabW-1:0]  tab_size_q;
  logic [lstt_pkg::TabW-1:0]  count_q, count_d;
  logic                       recording_q, recording_d;
  logic [lstt_pkg::TabW-1:0]  pend_cnt_q, pend_cnt_d;
  logic                       pend_vld_q, pend_vld_d;
  logic [lstt_pkg::ByteW-1:0] pend_chr_q, pend_chr_d;
  logic                       out_valid_q, out_valid_d;
  lstt_pkg::out_beat_t        out_beat_q, out_beat_d;

  logic           adv, pend_busy, acc;
  lstt_pkg::act_t act;

  lstt_decide u_decide (
    .beat_i      (in_beat_i),
    .count_i     (count_q),
    .recording_i (recording_q),
    .tab_size_i  (tab_size_q),
    .act_o       (act)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign pend_busy  = (pend_cnt_q != '0) || pend_vld_q;
  assign in_stall_o = pend_busy || !adv;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    count_d     = count_q;
    recording_d = recording_q;
    pend_cnt_d  = pend_cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_chr_d  = pend_chr_q;
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;

    if (adv) begin
      out_valid_d = 1'b0;
      if (pend_busy) begin
        out_valid_d = 1'b1;
        if (pend_cnt_q != '0) begin
          out_beat_d.out_byte    = lstt_pkg::CH_SPACE;
          out_beat_d.last_of_run = (pend_cnt_q == lstt_pkg::TabW'(1)) && !pend_vld_q;
          pend_cnt_d             = pend_cnt_q - lstt_pkg::TabW'(1);
        end else begin
          out_beat_d.out_byte    = pend_chr_q;
          out_beat_d.last_of_run = 1'b1;
          pend_vld_d             = 1'b0;
        end
      end else if (acc) begin
        count_d     = act.count_next;
        recording_d = act.recording_next;
        if (act.spaces != '0) begin
          out_valid_d            = 1'b1;
          out_beat_d.out_byte    = lstt_pkg::CH_SPACE;
          out_beat_d.last_of_run = (act.spaces == lstt_pkg::TabW'(1)) && !act.has_char;
          pend_cnt_d             = act.spaces - lstt_pkg::TabW'(1);
          pend_vld_d             = act.has_char;
          pend_chr_d             = act.emit_char;
        end else if (act.has_char) begin
          out_valid_d            = 1'b1;
          out_beat_d.out_byte    = act.emit_char;
          out_beat_d.last_of_run = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_size_q  <= lstt_pkg::TAB_SIZE_RESET;
      count_q     <= '0;
      recording_q <= 1'b1;
      pend_cnt_q  <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tab_size_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      recording_q <= recording_d;
      pend_cnt_q  <= pend_cnt_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_chr_q <= pend_chr_d;
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// ===== hdl/lstt_decide.sv =====
module lstt_decide (
  input  lstt_pkg::in_beat_t          beat_i,
  input  logic [lstt_pkg::TabW-1:0]   count_i,
  input  logic                        recording_i,
  input  logic [lstt_pkg::TabW-1:0]   tab_size_i,
  output lstt_pkg::act_t              act_o
);

  logic [lstt_pkg::TabW-1:0] ts;
  logic [lstt_pkg::TabW-1:0] cnt_inc;

  always_comb begin
    ts      = (tab_size_i == '0) ? lstt_pkg::TabW'(1) : tab_size_i;
    cnt_inc = count_i + lstt_pkg::TabW'(1);

    act_o                = '0;
    act_o.count_next     = count_i;
    act_o.recording_next = recording_i;

    if (beat_i.end_of_stream) begin
      act_o.spaces         = count_i;
      act_o.count_next     = '0;
      act_o.recording_next = 1'b1;
    end else if (recording_i && beat_i.in_byte == lstt_pkg::CH_SPACE) begin
      if (cnt_inc >= ts) begin
        act_o.has_char   = 1'b1;
        act_o.emit_char  = lstt_pkg::CH_TAB;
        act_o.count_next = '0;
      end else begin
        act_o.count_next = cnt_inc;
      end
    end else begin
      if (recording_i) begin
        act_o.spaces     = count_i;
        act_o.count_next = '0;
      end
      act_o.has_char       = 1'b1;
      act_o.emit_char      = beat_i.in_byte;
      act_o.recording_next = (beat_i.in_byte == lstt_pkg::CH_NEWLINE);
    end
  end

endmodule

// ===== hdl/lstt_checker.sv =====
module lstt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input lstt_pkg::out_beat_t         out_beat_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  // only flushed spaces can be followed by more beats of the same run
  a_mid_run_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.last_of_run |-> out_beat_o.out_byte == lstt_pkg::CH_SPACE)
    else $error("non-space beat inside a run");

  // a run still draining blocks the input
  a_drain_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.last_of_run |-> in_stall_o)
    else $error("input taken while a run drains");

  // empty output means nothing pending, so input is open
  a_idle_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind leading_space_to_tab lstt_checker u_lstt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ===== tb/sv/leading_space_to_tab_tb.sv =====
module leading_space_to_tab_tb;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles = 8;

  class tab_scoreboard;
    logic [lstt_pkg::TabW-1:0] tab_size;
    logic [lstt_pkg::TabW-1:0] space_count;
    logic                      recording;
    lstt_pkg::out_beat_t       pending_bytes[$];
    int                        errors;

    function new();
      tab_size    = lstt_pkg::TAB_SIZE_RESET;
      space_count = '0;
      recording   = 1'b1;
      errors      = 0;
    endfunction

    function void set_tab_size(logic [lstt_pkg::TabW-1:0] v);
      tab_size = v;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void push_byte(logic [lstt_pkg::ByteW-1:0] c);
      lstt_pkg::out_beat_t e;
      e.out_byte    = c;
      e.last_of_run = 1'b0;
      pending_bytes.push_back(e);
    endfunction

    function void flush_spaces();
      for (int i = 0; i < int'(space_count); i++) push_byte(lstt_pkg::CH_SPACE);
      space_count = '0;
    endfunction

    // predicts the bytes caused by one accepted input beat
    function void note_in_beat(lstt_pkg::in_beat_t b);
      int                        n0;
      logic [lstt_pkg::TabW-1:0] eff;
      lstt_pkg::out_beat_t       e;
      n0  = pending_bytes.size();
      eff = (tab_size == '0) ? lstt_pkg::TabW'(1) : tab_size;
      if (b.end_of_stream) begin
        flush_spaces();
        recording = 1'b1;
      end else if (recording && b.in_byte == lstt_pkg::CH_SPACE) begin
        space_count = space_count + 1'b1;
        if (space_count >= eff) begin
          push_byte(lstt_pkg::CH_TAB);
          space_count = '0;
        end
      end else begin
        if (recording) flush_spaces();
        push_byte(b.in_byte);
        recording = (b.in_byte == lstt_pkg::CH_NEWLINE);
      end
      if (pending_bytes.size() > n0) begin
        e = pending_bytes.pop_back();
        e.last_of_run = 1'b1;
        pending_bytes.push_back(e);
      end
    endfunction

    function void check_out_beat(lstt_pkg::out_beat_t got);
      lstt_pkg::out_beat_t exp_b;
      if (pending_bytes.size() == 0) begin
        $display("%0t unexpected beat: out_byte %0d last_of_run %0d",
                 $time, got.out_byte, got.last_of_run);
        errors++;
        return;
      end
      exp_b = pending_bytes.pop_front();
      if (got.out_byte !== exp_b.out_byte) begin
        $display("%0t out_byte mismatch: expected %0d, got %0d",
                 $time, exp_b.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_run !== exp_b.last_of_run) begin
        $display("%0t last_of_run mismatch: expected %0d, got %0d",
                 $time, exp_b.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  lstt_pkg::in_beat_t        in_beat_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  lstt_pkg::out_beat_t       out_beat_o;
  logic                      cfg_we_i = 1'b0;
  logic [lstt_pkg::TabW-1:0] cfg_wdata_i = '0;

  tab_scoreboard sb = new();
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;

  leading_space_to_tab DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_out_beat(out_beat_o);
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drive_beat(lstt_pkg::in_beat_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_in_beat(b);
    items_sent++;
  endtask

  task automatic send_byte(logic [lstt_pkg::ByteW-1:0] c);
    lstt_pkg::in_beat_t b;
    b.in_byte       = c;
    b.end_of_stream = 1'b0;
    drive_beat(b);
  endtask

  task automatic send_eos();
    lstt_pkg::in_beat_t b;
    b.in_byte       = lstt_pkg::ByteW'($urandom_range(255));
    b.end_of_stream = 1'b1;
    drive_beat(b);
  endtask

  task automatic send_line(int lead, int body_len);
    logic [lstt_pkg::ByteW-1:0] c;
    repeat (lead) send_byte(lstt_pkg::CH_SPACE);
    repeat (body_len) begin
      c = lstt_pkg::ByteW'($urandom_range(255));
      if ($urandom_range(4) == 0) c = lstt_pkg::CH_SPACE;
      send_byte(c);
    end
    send_byte(lstt_pkg::CH_NEWLINE);
  endtask

  // register writes only once all expected beats are out
  task automatic write_tab_size(logic [lstt_pkg::TabW-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_tab_size(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [lstt_pkg::TabW-1:0] tab, int idle_pct, int stall_pct,
                           int n, int lead0);
    int target;
    int pick;
    int lim;
    int lead;
    write_tab_size(tab);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    target = items_sent + n;
    if (lead0 > 0) send_line(lead0, 1);
    while (items_sent < target) begin
      pick = $urandom_range(99);
      lim  = ((tab == '0) ? 1 : int'(tab)) * 3 + 2;
      if (lim > 70) lim = 70;
      lead = ($urandom_range(7) == 0) ? $urandom_range(lim) : $urandom_range(12);
      if (pick < 75) begin
        send_line(lead, $urandom_range(6));
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0: send_byte(lstt_pkg::CH_SPACE);
          1: send_byte(lstt_pkg::CH_NEWLINE);
          default: send_byte(lstt_pkg::ByteW'($urandom_range(255)));
        endcase
      end else if (pick < 92) begin
        send_eos();
      end else begin
        // leading run cut short by end of stream
        repeat (lead) send_byte(lstt_pkg::CH_SPACE);
        send_eos();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at reset tab size
    begin
      lstt_pkg::in_beat_t b;
      b.in_byte       = 8'hFF;
      b.end_of_stream = 1'b1;
      drive_beat(b);
    end
    repeat (3) send_byte(lstt_pkg::CH_SPACE);
    send_byte(8'hFF);
    send_byte(lstt_pkg::CH_SPACE);
    send_byte(8'h00);
    send_byte(lstt_pkg::CH_NEWLINE);
    send_byte(lstt_pkg::CH_NEWLINE);
    repeat (9) send_byte(lstt_pkg::CH_SPACE);
    send_eos();
    send_byte(lstt_pkg::CH_TAB);
    send_byte(lstt_pkg::CH_NEWLINE);
    repeat (3) send_byte(lstt_pkg::CH_SPACE);

    // tab size drops below the pending count
    run_phase(lstt_pkg::TabW'(1), 0, 0, 50, 0);
    run_phase(lstt_pkg::TabW'(0), 48, 0, 50, 0);
    run_phase(lstt_pkg::TabW'(63), 0, 48, 70, 62);
    run_phase(lstt_pkg::TabW'(4), 21, 21, 55, 0);
    run_phase(lstt_pkg::TabW'($urandom_range(16, 2)), 48, 0, 55, 0);
    run_phase(lstt_pkg::TabW'($urandom_range(63, 1)), 0, 48, 55, 0);
    run_phase(lstt_pkg::TabW'(2), 0, 0, 50, 0);
    send_eos();

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/lstt_pkg.sv
hdl/lstt_decide.sv
hdl/leading_space_to_tab.sv
hdl/lstt_checker.sv
tb/sv/leading_space_to_tab_tb.sv
